FILE: rtl/rse_pkg.sv
package rse_pkg;
  localparam int MemWords = 1024;
  localparam int MemAw = $clog2(MemWords);
  localparam int LineW = 12;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_ADDI = 4'd1, OP_SUB = 4'd2, OP_SUBI = 4'd3, OP_SLT = 4'd4,
    OP_BEQ = 4'd5, OP_BNE = 4'd6, OP_J = 4'd7, OP_LW = 4'd8, OP_SW = 4'd9,
    OP_LA = 4'd10
  } op_t;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ALIGN = 2'd1;
  localparam logic [1:0] FAULT_RANGE = 2'd2;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] imm;
    logic [11:0] tgt;
  } instr_t;
endpackage

FILE: rtl/risc_subset_execute_unit.sv
// Execute unit for a small integer instruction subset.
// Input channel: in_valid / in_stall with one decoded instruction per
// transaction (op, registers, immediate, branch target).
// Output channel: out_valid / out_stall with one result per instruction:
// next line, taken flag, fault code and the register or store write.
// A two-entry queue takes instructions while the execute stage works.
// Results are registered: an instruction goes from S_EXEC to S_OUT, and a load
// without fault passes S_LOAD between them to read the synchronous data RAM.
// The execute sequencer takes no new instruction from the queue while it
// holds a result that has not yet been taken.
// While out_stall is high the result holds, execution halts and the queue
// fills, then in_stall rises.
// Reset clears the register file, the line counter and the queue; the data
// memory is not cleared and reads of unwritten words are undefined.
module risc_subset_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_src_reg_a,
  input  logic [4:0]  in_src_reg_b,
  input  logic [31:0] in_immediate,
  input  logic [11:0] in_target_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_next_line,
  output logic        out_taken,
  output logic [1:0]  out_fault,
  output logic        out_reg_written,
  output logic [4:0]  out_written_reg,
  output logic [31:0] out_written_value
);
  import rse_pkg::*;

  instr_t in_instr, q_instr;
  logic   q_valid, q_pop;

  assign in_instr = '{op: in_op, rd: in_dest_reg, ra: in_src_reg_a, rb: in_src_reg_b,
                      imm: in_immediate, tgt: in_target_line};

  rse_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_instr,
    .q_valid, .q_pop, .q_instr
  );

  rse_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_instr,
    .out_valid, .out_stall, .out_next_line, .out_taken, .out_fault,
    .out_reg_written, .out_written_reg, .out_written_value
  );

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault != FAULT_NONE |-> !out_reg_written && !out_taken)
    else $error("faulting instruction reported a write or branch");

  a_r0_never: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_written |-> out_written_reg != 5'd0)
    else $error("register zero reported as written");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
endmodule

FILE: rtl/rse_front.sv
module rse_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rse_pkg::instr_t      in_instr,
  output logic                 q_valid,
  input  logic                 q_pop,
  output rse_pkg::instr_t      q_instr
);
  import rse_pkg::*;

  // Two-entry queue between the accepting side and the execute side.
  instr_t     slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_instr = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_instr;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: rtl/rse_back.sv
module rse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_pop,
  input  rse_pkg::instr_t  q_instr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [11:0]      out_next_line,
  output logic             out_taken,
  output logic [1:0]       out_fault,
  output logic             out_reg_written,
  output logic [4:0]       out_written_reg,
  output logic [31:0]      out_written_value
);
  import rse_pkg::*;

  typedef enum logic [2:0] {
    S_EXEC = 3'b001, S_LOAD = 3'b010, S_OUT = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] rf_r [32];
  logic [31:0] mem_r [MemWords];
  logic [31:0] mem_q_r;
  logic [LineW-1:0] line_r;
  logic [4:0]  ld_rd_r;

  logic [31:0] va, vb, vd, addr, res;
  logic        wr, tk;
  logic [1:0]  flt;
  logic [MemAw-1:0] idx;
  logic [LineW-1:0] nxt;
  logic [31:0] wval;

  assign va = rf_r[q_instr.ra];
  assign vb = rf_r[q_instr.rb];
  assign vd = rf_r[q_instr.rd];
  assign addr = q_instr.imm + va;
  assign idx = addr[MemAw+1:2];
  assign q_pop = (state_r == S_EXEC) && q_valid;

  always_comb begin
    res = 32'd0;
    wr = 1'b0;
    tk = 1'b0;
    flt = FAULT_NONE;
    wval = 32'd0;
    if (q_instr.op == OP_LW || q_instr.op == OP_SW) begin
      if (addr[1:0] != 2'b00) flt = FAULT_ALIGN;
      else if (addr[31] || (addr[30:2] >= 29'(MemWords))) flt = FAULT_RANGE;
    end
    case (q_instr.op)
      OP_ADD:  begin res = va + vb; wr = 1'b1; end
      OP_ADDI: begin res = va + q_instr.imm; wr = 1'b1; end
      OP_SUB:  begin res = va - vb; wr = 1'b1; end
      OP_SUBI: begin res = va - q_instr.imm; wr = 1'b1; end
      OP_SLT:  begin res = {31'd0, $signed(va) < $signed(vb)}; wr = 1'b1; end
      OP_BEQ:  tk = (vd == va);
      OP_BNE:  tk = (vd != va);
      OP_J:    tk = 1'b1;
      // The loaded value itself arrives in the next cycle from the data RAM.
      OP_LW:   wr = (flt == FAULT_NONE);
      OP_SW:   if (flt == FAULT_NONE) wval = vd;
      OP_LA:   begin res = q_instr.imm; wr = 1'b1; end
      default: ;
    endcase
    if (wr && q_instr.rd != 5'd0) wval = res;
    else wr = 1'b0;
    nxt = tk ? q_instr.tgt : line_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_EXEC: if (q_valid) state_nxt = (q_instr.op == OP_LW && flt == FAULT_NONE)
                                       ? S_LOAD : S_OUT;
      S_LOAD: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_EXEC;
      default: state_nxt = S_EXEC;
    endcase
  end

  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    mem_q_r <= mem_r[idx];
    if (q_pop && q_instr.op == OP_SW && flt == FAULT_NONE) mem_r[idx] <= vd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EXEC;
      line_r <= '0;
      for (int i = 0; i < 32; i++) rf_r[i] <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        line_r <= nxt;
        if (wr && q_instr.op != OP_LW) rf_r[q_instr.rd] <= res;
      end
      if (state_r == S_LOAD && ld_rd_r != 5'd0) rf_r[ld_rd_r] <= mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ld_rd_r <= q_instr.rd;
      out_next_line <= nxt;
      out_taken <= tk;
      out_fault <= flt;
      out_reg_written <= wr;
      out_written_reg <= wr ? q_instr.rd : 5'd0;
      out_written_value <= wval;
    end else if (state_r == S_LOAD && ld_rd_r != 5'd0) begin
      out_written_value <= mem_q_r;
    end
  end
endmodule
